// File: hdl/owf_pkg.sv
// ----------------------------------------------------------------------------
// owf_pkg: shared types and constants of the overlap window framer
// register indexes, register widths and reset values, ring control bundle
// ----------------------------------------------------------------------------
package owf_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOP_LENGTH    = 1'b1;

    // register widths and reset values
    localparam int WIN_BITS = 7;
    localparam int HOP_BITS = 8;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd64;
    localparam logic [HOP_BITS-1:0] HOP_RESET = 8'd32;

    // control from the sequencer to the history ring
    typedef struct packed {
        logic wr_en;   // store the incoming sample
        logic clr;     // drop the whole history (restart)
        logic rd_en;   // load one ring entry into the output register
    } t_ring_ctl;

endpackage

// File: hdl/owf_ring.sv
// ----------------------------------------------------------------------------
// owf_ring: history ring of the overlap window framer
// one write port, one registered read port, per-entry valid flags so that
// reset and restart empty the ring at once (an empty entry reads as zero)
// ----------------------------------------------------------------------------
module owf_ring #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  owf_pkg::t_ring_ctl            i_ctl,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]        i_wr_data,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_rd_addr,
    output logic [SAMPLE_BITS-1:0]        o_rd_data
);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  r_valid;
    logic [WINDOW_MAX-1:0]  n_valid;
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // valid flags: clear on restart, then mark the entry being written
    always_comb begin
        n_valid = i_ctl.clr ? '0 : r_valid;
        if (i_ctl.wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // sample storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, empty entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/owf_seq.sv
// ----------------------------------------------------------------------------
// owf_seq: sequencer of the overlap window framer
// tracks hop position and ring pointer, and walks the single ring read port
// over the window at hop end (or over the one pass-through entry)
// ----------------------------------------------------------------------------
module owf_seq #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [owf_pkg::WIN_BITS-1:0]  i_window_length,
    input  logic [owf_pkg::HOP_BITS-1:0]  i_hop_length,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    output owf_pkg::t_ring_ctl            o_ring_ctl,
    output logic [$clog2(WINDOW_MAX)-1:0] o_wr_addr,
    output logic [$clog2(WINDOW_MAX)-1:0] o_rd_addr,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_out_last
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = $clog2(2 * WINDOW_MAX) + 1;
    localparam int WB = owf_pkg::WIN_BITS;
    localparam int HB = owf_pkg::HOP_BITS;
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [SW-1:0] WMAX_S    = SW'(WINDOW_MAX);
    localparam logic [WB-1:0] WMAX_W    = WB'(WINDOW_MAX);

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_wp;
    logic [HB-1:0] r_hop_pos;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_cnt;
    logic          r_last_ok;
    logic          r_out_valid;
    logic          r_out_last;

    logic [WB-1:0] win_eff;
    logic [CW-1:0] win_cnt;
    logic [HB-1:0] hop_eff;
    logic [AW-1:0] wp_cur;
    logic [AW-1:0] wp_next;
    logic [HB-1:0] pos;
    logic          hop_end;
    logic          overlap;
    logic          pass_hit;
    logic          pass_last;
    logic [SW-1:0] start_sum;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] addr_inc;
    logic          accept;
    logic          issue;

    // effective register values
    always_comb begin
        if (i_window_length == '0) begin
            win_eff = WB'(1);
        end else if (i_window_length > WMAX_W) begin
            win_eff = WMAX_W;
        end else begin
            win_eff = i_window_length;
        end
        hop_eff = (i_hop_length == '0) ? HB'(1) : i_hop_length;
        win_cnt = CW'(win_eff);
    end

    // hop bookkeeping for the incoming sample, restart applied first
    always_comb begin
        wp_cur    = i_restart ? '0 : r_wp;
        pos       = i_restart ? '0 : r_hop_pos;
        wp_next   = (wp_cur == ADDR_LAST) ? '0 : wp_cur + AW'(1);
        hop_end   = ({1'b0, pos} + (HB+1)'(1)) >= {1'b0, hop_eff};
        overlap   = hop_eff < {1'b0, win_eff};
        pass_hit  = pos < {1'b0, win_eff};
        pass_last = ({1'b0, pos} + (HB+1)'(1)) == {2'b0, win_eff};
        // oldest window entry: (wp_next + WINDOW_MAX - w) mod WINDOW_MAX
        start_sum = SW'(wp_next) + WMAX_S - SW'(win_cnt);
        if (start_sum >= WMAX_S) begin
            start_addr = AW'(start_sum - WMAX_S);
        end else begin
            start_addr = AW'(start_sum);
        end
        addr_inc = (r_addr == ADDR_LAST) ? '0 : r_addr + AW'(1);
    end

    // handshakes and ring control
    always_comb begin
        accept           = i_in_valid && (r_state == S_IDLE);
        issue            = (r_state == S_READ) && (!r_out_valid || i_out_ready);
        o_ring_ctl.wr_en = accept;
        o_ring_ctl.clr   = accept && i_restart;
        o_ring_ctl.rd_en = issue;
    end

    // state, pointers and output flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_hop_pos   <= '0;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_last_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            // output register holds until taken
            if (issue) begin
                r_out_valid <= 1'b1;
                r_out_last  <= (r_cnt == CW'(1)) && r_last_ok;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_wp      <= wp_next;
                        r_hop_pos <= hop_end ? '0 : pos + HB'(1);
                        if (overlap && hop_end) begin
                            r_state   <= S_READ;
                            r_addr    <= start_addr;
                            r_cnt     <= win_cnt;
                            r_last_ok <= 1'b1;
                        end else if (!overlap && pass_hit) begin
                            r_state   <= S_READ;
                            r_addr    <= wp_cur;
                            r_cnt     <= CW'(1);
                            r_last_ok <= pass_last;
                        end
                    end
                end
                S_READ: begin
                    if (issue) begin
                        r_addr <= addr_inc;
                        r_cnt  <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_wr_addr   = wp_cur;
    assign o_rd_addr   = r_addr;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;

endmodule

// File: hdl/overlap_window_framer.sv
// ----------------------------------------------------------------------------
// overlap_window_framer: sliding window framer with overlap for one channel
// every sample enters a history ring; at hop end a full window is read back
// oldest first, or in pass-through mode the first window samples of a hop
//
// channel   direction  request carries                     handshake
// s_axis    in         sample_in (tdata), restart (tuser)   tvalid/tready
// m_axis    out        sample_out (tdata), window_last      tvalid/tready
//                      (tlast)
// cfg       in         register index, write data           valid/ready
//
// a sample that ends no window is taken while idle and leaves ready high
// a hop-end sample in overlap mode drops ready while the single ring read port
// delivers one window sample per cycle while m_axis is ready
// a pass-through sample drops ready for one ring read
// output stalls hold the burst; the input waits until the last read is issued
// reset and restart empty the ring at once through per-entry valid flags
// ----------------------------------------------------------------------------
module overlap_window_framer #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input samples
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,   // sample_in
    input  logic                                  i_s_axis_tuser,   // restart
    // window samples
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      o_m_axis_tdata,   // sample_out
    output logic                                  o_m_axis_tlast,   // window_last
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [owf_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [owf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [owf_pkg::WIN_BITS-1:0] r_window_length;
    logic [owf_pkg::HOP_BITS-1:0] r_hop_length;
    owf_pkg::t_ring_ctl           ring_ctl;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [SAMPLE_BITS-1:0]       rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= owf_pkg::WIN_RESET;
            r_hop_length    <= owf_pkg::HOP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owf_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[owf_pkg::WIN_BITS-1:0];
                end
                owf_pkg::CFG_HOP_LENGTH: begin
                    r_hop_length <= i_cfg_data[owf_pkg::HOP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer
    owf_seq #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_hop_length    (r_hop_length),
        .i_in_valid      (i_s_axis_tvalid),
        .o_in_ready      (o_s_axis_tready),
        .i_restart       (i_s_axis_tuser),
        .o_ring_ctl      (ring_ctl),
        .o_wr_addr       (wr_addr),
        .o_rd_addr       (rd_addr),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_out_last      (o_m_axis_tlast)
    );

    // history ring, its read register is the output data register
    owf_ring #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ring_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_axis_tdata = DW'(rd_data);

    // a ring read never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.rd_en |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("ring read while output register still full");

    // every ring read shows up as an output request
    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.rd_en |=> o_m_axis_tvalid)
        else $error("ring read did not produce an output request");

    // reads and sample writes never share a cycle
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_ctl.rd_en && ring_ctl.wr_en))
        else $error("ring read and write in the same cycle");

    // a history clear only comes with an accepted sample
    a_clr_with_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.clr |-> (ring_ctl.wr_en && i_s_axis_tvalid && o_s_axis_tready))
        else $error("history cleared without an accepted sample");

endmodule

// File: sim/owf_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owf_window_checker: scoreboard for the overlap window framer
// follows register writes and accepted input samples with its own copy of
// the history ring and hop counter, queues the window samples each request
// should produce and compares every output request against the oldest one
// ----------------------------------------------------------------------------
module owf_window_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input sample channel
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    input  logic [15:0]                         i_s_axis_tdata,   // sample_in
    input  logic                                i_s_axis_tuser,   // restart
    // window sample channel
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [15:0]                         i_m_axis_tdata,   // sample_out
    input  logic                                i_m_axis_tlast,   // window_last
    // configuration writes
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [owf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [owf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // status to the test
    output int                                  o_fail_count,
    output int                                  o_samples_due
);

    localparam int RING_DEPTH = 64;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_window_sample;

    t_window_sample                 due_samples[$];
    t_window_sample                 head;
    logic [15:0]                    history [RING_DEPTH];
    logic [5:0]                     write_ptr;
    logic [7:0]                     hop_pos;
    logic [owf_pkg::WIN_BITS-1:0]   window_reg;
    logic [owf_pkg::HOP_BITS-1:0]   hop_reg;
    int                             fails = 0;

    // take one sample into the ring and queue the window samples it releases
    task automatic frame_sample(input logic [15:0] smp, input logic restart);
        int             w;
        int             h;
        int             pos;
        int             start;
        bit             hop_end;
        t_window_sample item;
        // out-of-range lengths clamp to the usable range
        w = (window_reg == 0) ? 1 :
            (window_reg > RING_DEPTH) ? RING_DEPTH : int'(window_reg);
        h = (hop_reg == 0) ? 1 : int'(hop_reg);
        if (restart) begin
            foreach (history[i]) history[i] = '0;
            write_ptr = '0;
            hop_pos   = '0;
        end
        // the ring is written in both modes
        history[write_ptr] = smp;
        write_ptr = write_ptr + 1'b1;
        pos = int'(hop_pos);
        hop_end = (pos + 1) >= h;
        if (h < w) begin
            // overlap mode: whole window at hop end, oldest first
            if (hop_end) begin
                start = (int'(write_ptr) + RING_DEPTH - w) % RING_DEPTH;
                for (int k = 0; k < w; k++) begin
                    item.sample = history[(start + k) % RING_DEPTH];
                    item.last   = (k == w - 1);
                    due_samples.push_back(item);
                end
            end
        end else if (pos < w) begin
            // pass-through mode: head of each hop goes straight out
            item.sample = smp;
            item.last   = (pos + 1 == w);
            due_samples.push_back(item);
        end
        hop_pos = hop_end ? 8'd0 : 8'(pos + 1);
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (history[i]) history[i] = '0;
            write_ptr  = '0;
            hop_pos    = '0;
            window_reg = owf_pkg::WIN_RESET;
            hop_reg    = owf_pkg::HOP_RESET;
            due_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == owf_pkg::CFG_WINDOW_LENGTH) begin
                    window_reg = i_cfg_data[owf_pkg::WIN_BITS-1:0];
                end else if (i_cfg_index == owf_pkg::CFG_HOP_LENGTH) begin
                    hop_reg = i_cfg_data[owf_pkg::HOP_BITS-1:0];
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                frame_sample(i_s_axis_tdata, i_s_axis_tuser);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (due_samples.size() == 0) begin
                    $error("sample_out: expected none, actual %h", i_m_axis_tdata);
                    fails++;
                end else begin
                    head = due_samples.pop_front();
                    if (i_m_axis_tdata !== head.sample) begin
                        $error("sample_out: expected %h, actual %h",
                               head.sample, i_m_axis_tdata);
                        fails++;
                    end
                    if (i_m_axis_tlast !== head.last) begin
                        $error("window_last: expected %b, actual %b",
                               head.last, i_m_axis_tlast);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_samples_due <= due_samples.size();
    end

endmodule

// File: sim/overlap_window_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_window_framer_test: regression for the overlap window framer
// directed samples cover extreme values, restart, start-up zeros, mid-hop
// length changes, pass-through mode and clamped lengths; random phases then
// vary window and hop with random gaps and output stalls, while a separate
// checker predicts and compares every window sample
// ----------------------------------------------------------------------------
module overlap_window_framer_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 107;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic [15:0]                         s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                s_tready;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [15:0]                         m_tdata;
    logic                                m_tlast;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [owf_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [owf_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

    int  fail_count;
    int  samples_due;
    int  cycle_count = 0;
    int  out_hold = 0;
    int  stall_draw;
    bit  calm = 1'b0;

    always #5 i_clk = ~i_clk;

    overlap_window_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    owf_window_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_samples_due   (samples_due)
    );

    // idle cycles before the next request, none in calm stretches
    function automatic int draw_gap();
        if (calm) return 0;
        return $urandom_range(0, 10);
    endfunction

    // window sample back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            out_hold <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                stall_draw = draw_gap();
                out_hold <= stall_draw;
                m_tready <= (stall_draw == 0);
            end
        end else if (out_hold <= 1) begin
            m_tready <= 1'b1;
            out_hold <= 0;
        end else begin
            out_hold <= out_hold - 1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one sample and wait for its request to be taken
    task automatic send_sample(input logic [15:0] smp, input logic restart);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= restart;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop sending and wait until every due window sample has come out
    task automatic drain_windows();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (samples_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both framing registers while the block is idle
    task automatic set_framing(input logic [owf_pkg::WIN_BITS-1:0] win,
                               input logic [owf_pkg::HOP_BITS-1:0] hop);
        drain_windows();
        cfg_valid <= 1'b1;
        cfg_index <= owf_pkg::CFG_WINDOW_LENGTH;
        cfg_data  <= {1'($urandom_range(0, 1)), win};
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= owf_pkg::CFG_HOP_LENGTH;
        cfg_data  <= hop;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int random_sent;
        int n;
        int w;
        int h;
        random_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start-up zeros and extreme sample values, short overlap windows
        set_framing(7'd4, 8'd2);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        // restart in the middle of a hop
        send_sample(16'h0001, 1'b0);
        send_sample(16'h5A5A, 1'b1);
        send_sample(16'hA5A5, 1'b0);
        // hop shortened below the current position
        set_framing(7'd4, 8'd3);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFEDC, 1'b0);
        set_framing(7'd4, 8'd2);
        send_sample(16'h4321, 1'b0);
        // pass-through: head of hop passes, tail dropped
        set_framing(7'd3, 8'd5);
        repeat (5) send_sample(16'($urandom), 1'b0);
        // back to overlap, ring still holds pass-through samples
        set_framing(7'd6, 8'd2);
        repeat (2) send_sample(16'($urandom), 1'b0);
        // zero lengths clamp up to one
        set_framing(7'd0, 8'd0);
        repeat (2) send_sample(16'($urandom), 1'b0);
        // oversize window clamps to the ring depth, longest hop
        set_framing(7'd127, 8'd255);
        repeat (2) send_sample(16'($urandom), 1'b0);
        // full window on every sample
        set_framing(7'd64, 8'd1);
        repeat (2) send_sample(16'($urandom), 1'b0);

        // random phases of framing settings
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    w = $urandom_range(2, 16);
                    h = $urandom_range(1, w - 1);
                end
                3: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(w, w + 6);
                end
                4: begin
                    w = 64;
                    h = $urandom_range(16, 63);
                end
                default: begin
                    w = $urandom_range(0, 127);
                    h = $urandom_range(0, 255);
                end
            endcase
            set_framing(7'(w), 8'(h));
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(8, 24);
            if (n > RANDOM_ITEMS - random_sent) begin
                n = RANDOM_ITEMS - random_sent;
            end
            repeat (n) begin
                send_sample(16'($urandom), 1'($urandom_range(0, 39) == 0));
                random_sent++;
            end
        end

        // let the last windows drain
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (samples_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
